// File: hdl/rpsh_pkg.sv
// Shared types and constants for the route path signature hash.
// Used by every module of the block; no dependencies.
package rpsh_pkg;

    localparam int METHOD_BYTES = 4;
    localparam int HASH_W       = 64;
    localparam int HALF_W       = HASH_W / 2;
    localparam int BYTE_W       = 8;
    localparam int BUCKET_W     = 16;

    localparam logic [HASH_W-1:0] OFFSET_BASIS = 64'hcbf29ce484222325;
    localparam logic [HASH_W-1:0] MUL_HIGH     = 64'd1099511628211;
    localparam logic [HASH_W-1:0] MUL_LOW      = 64'h9e3779b185ebca87;
    localparam logic [HASH_W-1:0] FOLD_ADD     = 64'h9e3779b97f4a7c15;
    localparam logic [HASH_W-1:0] FIN_MUL1     = 64'hbf58476d1ce4e5b9;
    localparam logic [HASH_W-1:0] FIN_MUL2     = 64'h94d049bb133111eb;
    localparam logic [BYTE_W-1:0] SLASH        = 8'h2f;
    localparam logic [BUCKET_W-1:0] BUCKET_RESET = 16'd4099;

    localparam int FIN_SHIFT1 = 30;
    localparam int FIN_SHIFT2 = 27;
    localparam int FIN_SHIFT3 = 31;

    localparam int NSTEPS    = METHOD_BYTES + 3;
    localparam int STEP_W    = $clog2(NSTEPS + 1);
    localparam int STEP_PRE  = METHOD_BYTES;
    localparam int STEP_CHAR = METHOD_BYTES + 1;
    localparam int STEP_END  = METHOD_BYTES + 2;

    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam int DIV_CNT_W = $clog2(HASH_W);

    typedef struct packed {
        logic [BYTE_W-1:0] method_code;
        logic [BYTE_W-1:0] path_byte;
        logic              first_byte;
        logic              last_byte;
    } t_in_word;

    typedef struct packed {
        logic [HASH_W-1:0]   signature_high;
        logic [HASH_W-1:0]   signature_low;
        logic [BUCKET_W-1:0] bucket_index;
    } t_out_word;

    typedef struct packed {
        logic [BYTE_W-1:0] method_code;
        logic [BYTE_W-1:0] path_byte;
        logic              do_method;
        logic              do_pre_slash;
        logic              do_char;
        logic              do_end_slash;
        logic              last;
    } t_cmd;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SEL,
        BK_MIX_WAIT,
        BK_FOLD,
        BK_FIN1,
        BK_FIN1_WAIT,
        BK_FIN2,
        BK_FIN2_WAIT,
        BK_DIV,
        BK_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        MP_LL,
        MP_HL,
        MP_LH
    } t_mul_phase;

endpackage

// File: hdl/route_path_signature_hash.sv
// Top level of the route path signature hash: config register and the
// front end, command queue and hash engine. Depends on rpsh_pkg,
// rpsh_front, rpsh_queue and rpsh_back.
//
// Input words carry one path byte each; first_byte restarts the hash and
// mixes the method code, last_byte closes the path and produces one result
// word with both 64-bit lanes and the bucket index. Both channels use
// valid/ready. The front end classifies each word (slash runs, segment
// starts) and places a mix command in a two-entry queue, so input words are
// taken while the engine is busy and while a result waits at the output.
// Each lane mix runs a 32x32 multiplier three times; a word costs one mix
// per character, plus one for a segment start and four for the method, and
// a fetch from the queue. A last word adds the fold, two finalizer multiplies,
// a 64-step remainder by the bucket total and the output step.
// The bucket total is written through i_cfg_we/i_cfg_wdata; it is to be
// written only while the block is idle, which the block does not enforce.
// Reset sets both lanes to the offset basis, the bucket total to 4099 and
// empties the queue. A stalled receiver holds the result word; the engine
// then waits at its output step and the queue fills before o_ready drops.
module route_path_signature_hash import rpsh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [BUCKET_W-1:0] i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_in_word            i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out_word           o_word
);

    logic [BUCKET_W-1:0] r_bucket_total;
    logic                w_q_ready;
    logic                w_push;
    t_cmd                w_push_cmd;
    logic                w_q_valid;
    t_cmd                w_q_cmd;
    logic                w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_total <= BUCKET_RESET;
        end else if (i_cfg_we) begin
            r_bucket_total <= i_cfg_wdata;
        end
    end

    rpsh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_word    (i_word),
        .o_ready   (o_ready),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    rpsh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    rpsh_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_total (r_bucket_total),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_cmd),
        .o_q_pop        (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_word         (o_word)
    );

endmodule

// File: hdl/rpsh_front.sv
// Front end: accepts path words, tracks segment state, emits mix commands.
// Depends on rpsh_pkg.
module rpsh_front import rpsh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_word,
    output logic     o_ready,
    input  logic     i_q_ready,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic r_inside;
    logic r_seen;
    logic n_inside;
    logic n_seen;
    logic v_inside;
    logic v_seen;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        v_inside = i_word.first_byte ? 1'b0 : r_inside;
        v_seen   = i_word.first_byte ? 1'b0 : r_seen;
        o_cmd.method_code  = i_word.method_code;
        o_cmd.path_byte    = i_word.path_byte;
        o_cmd.do_method    = i_word.first_byte;
        o_cmd.do_pre_slash = 1'b0;
        o_cmd.do_char      = 1'b0;
        o_cmd.last         = i_word.last_byte;
        n_inside = v_inside;
        n_seen   = v_seen;
        if (i_word.path_byte == SLASH) begin
            n_inside = 1'b0;
        end else if (i_word.path_byte != '0) begin
            o_cmd.do_pre_slash = !v_inside;
            o_cmd.do_char      = 1'b1;
            n_inside = 1'b1;
            n_seen   = 1'b1;
        end
        o_cmd.do_end_slash = i_word.last_byte && !n_seen;
        if (i_word.last_byte) begin
            n_inside = 1'b0;
            n_seen   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_seen   <= 1'b0;
        end else if (o_push) begin
            r_inside <= n_inside;
            r_seen   <= n_seen;
        end
    end

endmodule

// File: hdl/rpsh_queue.sv
// Short command queue between the front end and the hash engine.
// Depends on rpsh_pkg.
module rpsh_queue import rpsh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_ready = r_count != Q_CNT_W'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != Q_CNT_W'(Q_DEPTH))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue pop while empty");

endmodule

// File: hdl/rpsh_mul64.sv
// Low half of a 64x64 product over three passes of one 32x32 multiplier.
// Depends on rpsh_pkg.
module rpsh_mul64 import rpsh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HASH_W-1:0] i_a,
    input  logic [HASH_W-1:0] i_b,
    output logic              o_done,
    output logic [HASH_W-1:0] o_prod
);

    logic [HASH_W-1:0] r_a;
    logic [HASH_W-1:0] r_b;
    logic [HASH_W-1:0] r_acc;
    t_mul_phase        r_phase;
    logic              r_busy;
    logic              r_done;
    logic [HASH_W-1:0] n_a;
    logic [HASH_W-1:0] n_b;
    logic [HASH_W-1:0] n_acc;
    t_mul_phase        n_phase;
    logic              n_busy;
    logic              n_done;
    logic [HALF_W-1:0] v_x;
    logic [HALF_W-1:0] v_y;
    logic [HASH_W-1:0] v_p;

    assign o_done = r_done;
    assign o_prod = r_acc;

    always_comb begin
        unique case (r_phase)
            MP_LL: begin
                v_x = r_a[HALF_W-1:0];
                v_y = r_b[HALF_W-1:0];
            end
            MP_HL: begin
                v_x = r_a[HASH_W-1:HALF_W];
                v_y = r_b[HALF_W-1:0];
            end
            MP_LH: begin
                v_x = r_a[HALF_W-1:0];
                v_y = r_b[HASH_W-1:HALF_W];
            end
            default: begin
                v_x = '0;
                v_y = '0;
            end
        endcase
        v_p = HASH_W'(v_x) * HASH_W'(v_y);
    end

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_phase = r_phase;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_a     = i_a;
            n_b     = i_b;
            n_phase = MP_LL;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            unique case (r_phase)
                MP_LL: begin
                    n_acc   = v_p;
                    n_phase = MP_HL;
                end
                MP_HL: begin
                    n_acc[HASH_W-1:HALF_W] = r_acc[HASH_W-1:HALF_W] + v_p[HALF_W-1:0];
                    n_phase = MP_LH;
                end
                MP_LH: begin
                    n_acc[HASH_W-1:HALF_W] = r_acc[HASH_W-1:HALF_W] + v_p[HALF_W-1:0];
                    n_phase = MP_LL;
                    n_busy  = 1'b0;
                    n_done  = 1'b1;
                end
                default: begin
                    n_phase = MP_LL;
                    n_busy  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MP_LL;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier restarted while busy");

endmodule

// File: hdl/rpsh_back.sv
// Hash engine: runs the lane mixes, finalizer and bucket remainder per command.
// Depends on rpsh_pkg and rpsh_mul64.
module rpsh_back import rpsh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [BUCKET_W-1:0] i_bucket_total,
    input  logic                i_q_valid,
    input  t_cmd                i_q_cmd,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out_word           o_word
);

    t_back_state         r_state;
    t_cmd                r_cmd;
    logic [STEP_W-1:0]   r_step;
    logic [HASH_W-1:0]   r_lane_hi;
    logic [HASH_W-1:0]   r_lane_lo;
    logic [HASH_W-1:0]   r_h;
    logic [BUCKET_W-1:0] r_rem;
    logic [BUCKET_W-1:0] r_div;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                r_out_valid;
    t_out_word           r_out;

    t_back_state         n_state;
    t_cmd                n_cmd;
    logic [STEP_W-1:0]   n_step;
    logic [HASH_W-1:0]   n_lane_hi;
    logic [HASH_W-1:0]   n_lane_lo;
    logic [HASH_W-1:0]   n_h;
    logic [BUCKET_W-1:0] n_rem;
    logic [BUCKET_W-1:0] n_div;
    logic [DIV_CNT_W-1:0] n_div_cnt;
    logic                n_out_valid;
    t_out_word           n_out;

    logic [NSTEPS-1:0]   v_en;
    logic                v_found;
    logic [STEP_W-1:0]   v_idx;
    logic [BYTE_W-1:0]   v_byte;
    logic [HASH_W-1:0]   v_byte_ext;
    logic [BUCKET_W:0]   v_shift;
    logic                v_start_hi;
    logic                v_start_lo;
    logic [HASH_W-1:0]   v_a_hi;
    logic [HASH_W-1:0]   v_b_hi;
    logic                w_done_hi;
    logic                w_done_lo;
    logic [HASH_W-1:0]   w_prod_hi;
    logic [HASH_W-1:0]   w_prod_lo;

    rpsh_mul64 u_mul_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (v_start_hi),
        .i_a     (v_a_hi),
        .i_b     (v_b_hi),
        .o_done  (w_done_hi),
        .o_prod  (w_prod_hi)
    );

    rpsh_mul64 u_mul_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (v_start_lo),
        .i_a     (r_lane_lo ^ v_byte_ext),
        .i_b     (MUL_LOW),
        .o_done  (w_done_lo),
        .o_prod  (w_prod_lo)
    );

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_comb begin
        for (int k = 0; k < NSTEPS; k++) begin
            if (k < METHOD_BYTES) begin
                v_en[k] = r_cmd.do_method;
            end else if (k == STEP_PRE) begin
                v_en[k] = r_cmd.do_pre_slash;
            end else if (k == STEP_CHAR) begin
                v_en[k] = r_cmd.do_char;
            end else begin
                v_en[k] = r_cmd.do_end_slash;
            end
        end
        v_found = 1'b0;
        v_idx   = '0;
        for (int k = NSTEPS - 1; k >= 0; k--) begin
            if (v_en[k] && (STEP_W'(k) >= r_step)) begin
                v_found = 1'b1;
                v_idx   = STEP_W'(k);
            end
        end
        if (v_idx == STEP_W'(STEP_PRE) || v_idx == STEP_W'(STEP_END)) begin
            v_byte = SLASH;
        end else if (v_idx == STEP_W'(STEP_CHAR)) begin
            v_byte = r_cmd.path_byte;
        end else if (v_idx == '0) begin
            v_byte = r_cmd.method_code;
        end else begin
            v_byte = '0;
        end
        v_byte_ext = {{(HASH_W - BYTE_W){1'b0}}, v_byte};
        v_shift    = {r_rem, r_h[HASH_W-1]};
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_step      = r_step;
        n_lane_hi   = r_lane_hi;
        n_lane_lo   = r_lane_lo;
        n_h         = r_h;
        n_rem       = r_rem;
        n_div       = r_div;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        v_start_hi  = 1'b0;
        v_start_lo  = 1'b0;
        v_a_hi      = r_lane_hi ^ v_byte_ext;
        v_b_hi      = MUL_HIGH;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_step  = '0;
                    if (i_q_cmd.do_method) begin
                        n_lane_hi = OFFSET_BASIS;
                        n_lane_lo = OFFSET_BASIS;
                    end
                    n_state = BK_SEL;
                end
            end
            BK_SEL: begin
                if (v_found) begin
                    v_start_hi = 1'b1;
                    v_start_lo = 1'b1;
                    n_step     = v_idx + STEP_W'(1);
                    n_state    = BK_MIX_WAIT;
                end else if (r_cmd.last) begin
                    n_state = BK_FOLD;
                end else if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_step  = '0;
                    if (i_q_cmd.do_method) begin
                        n_lane_hi = OFFSET_BASIS;
                        n_lane_lo = OFFSET_BASIS;
                    end
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_MIX_WAIT: begin
                if (w_done_hi && w_done_lo) begin
                    n_lane_hi = w_prod_hi;
                    n_lane_lo = w_prod_lo;
                    n_state   = BK_SEL;
                end
            end
            BK_FOLD: begin
                n_h     = r_lane_hi ^ (r_lane_lo + FOLD_ADD);
                n_div   = i_bucket_total;
                n_state = BK_FIN1;
            end
            BK_FIN1: begin
                v_start_hi = 1'b1;
                v_a_hi     = r_h ^ (r_h >> FIN_SHIFT1);
                v_b_hi     = FIN_MUL1;
                n_state    = BK_FIN1_WAIT;
            end
            BK_FIN1_WAIT: begin
                if (w_done_hi) begin
                    n_h     = w_prod_hi ^ (w_prod_hi >> FIN_SHIFT2);
                    n_state = BK_FIN2;
                end
            end
            BK_FIN2: begin
                v_start_hi = 1'b1;
                v_a_hi     = r_h;
                v_b_hi     = FIN_MUL2;
                n_state    = BK_FIN2_WAIT;
            end
            BK_FIN2_WAIT: begin
                if (w_done_hi) begin
                    n_h       = w_prod_hi ^ (w_prod_hi >> FIN_SHIFT3);
                    n_rem     = '0;
                    n_div_cnt = '0;
                    n_state   = BK_DIV;
                end
            end
            BK_DIV: begin
                if (v_shift >= {1'b0, r_div}) begin
                    n_rem = BUCKET_W'(v_shift - {1'b0, r_div});
                end else begin
                    n_rem = v_shift[BUCKET_W-1:0];
                end
                n_h       = {r_h[HASH_W-2:0], 1'b0};
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == '1) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.signature_high = r_lane_hi;
                    n_out.signature_low  = r_lane_lo;
                    n_out.bucket_index   = (r_div == '0) ? '0 : r_rem;
                    n_lane_hi            = OFFSET_BASIS;
                    n_lane_lo            = OFFSET_BASIS;
                    n_state              = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_step    <= n_step;
        r_h       <= n_h;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_div_cnt <= n_div_cnt;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_lane_hi   <= OFFSET_BASIS;
            r_lane_lo   <= OFFSET_BASIS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lane_hi   <= n_lane_hi;
            r_lane_lo   <= n_lane_lo;
            r_out_valid <= n_out_valid;
        end
    end

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == BK_OUT)
        else $error("result word raised outside the output step");

    a_mix_lanes_paired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_MIX_WAIT) |-> (w_done_hi == w_done_lo))
        else $error("lane multipliers out of step");

endmodule
